/* hw/rtl/rle_pkg.sv */
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types and constants of the ring leader election node.
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam int unsigned IdW       = 16;
  localparam int unsigned HopW      = 10;
  localparam int unsigned RingW     = 11;
  localparam int unsigned PhaseW    = 4;
  localparam int unsigned TallyW    = 32;
  localparam int unsigned ReplyW    = 2;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [PhaseW-1:0] MaxPhase = PhaseW'(9);
  localparam logic [HopW-1:0]   HopCap   = HopW'(512);
  localparam logic [RingW-1:0]  MinRing  = RingW'(2);
  localparam logic [RingW-1:0]  MaxRing  = RingW'(1024);
  localparam logic [ReplyW-1:0] ReplyMax = ReplyW'(3);
  localparam logic [ReplyW-1:0] ReplyOk  = ReplyW'(2);

  typedef enum logic [1:0] {
    OP_BEGIN    = 2'd0,
    OP_MESSAGE  = 2'd1,
    OP_CLOSE    = 2'd2,
    OP_ANNOUNCE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_PROBE    = 2'd0,
    KIND_REPLY    = 2'd1,
    KIND_ANNOUNCE = 2'd2,
    KIND_STATUS   = 2'd3
  } kind_e;

  typedef enum logic {
    MSG_PROBE = 1'b0,
    MSG_REPLY = 1'b1
  } msg_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OWN_ID    = 1'b0,
    REG_RING_SIZE = 1'b1
  } reg_e;

  localparam logic SideLeft  = 1'b0;
  localparam logic SideRight = 1'b1;

  typedef struct packed {
    logic              out_side;
    logic [1:0]        out_kind;
    logic [IdW-1:0]    out_id;
    logic [HopW-1:0]   out_hops;
    logic              still_candidate;
    logic              election_done;
    logic [IdW-1:0]    leader_id;
    logic [TallyW-1:0] messages_sent;
    logic              last;
  } result_t;

endpackage

/* hw/rtl/rle_in_if.sv */
// ----------------------------------------------------------------------------
// rle_in_if
// Request channel carrying one ring event into the node.
// ----------------------------------------------------------------------------
interface rle_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic                     from_side;
  logic                     msg_kind;
  logic [rle_pkg::IdW-1:0]  msg_id;
  logic [rle_pkg::HopW-1:0] msg_hops;

  modport source (output valid, operation, from_side, msg_kind, msg_id, msg_hops,
                  input ready);
  modport sink   (input valid, operation, from_side, msg_kind, msg_id, msg_hops,
                  output ready);
endinterface

/* hw/rtl/rle_out_if.sv */
// ----------------------------------------------------------------------------
// rle_out_if
// Result channel carrying sent messages and node status.
// ----------------------------------------------------------------------------
interface rle_out_if;
  logic                       valid;
  logic                       ready;
  logic                       out_side;
  logic [1:0]                 out_kind;
  logic [rle_pkg::IdW-1:0]    out_id;
  logic [rle_pkg::HopW-1:0]   out_hops;
  logic                       still_candidate;
  logic                       election_done;
  logic [rle_pkg::IdW-1:0]    leader_id;
  logic [rle_pkg::TallyW-1:0] messages_sent;
  logic                       last;

  modport source (output valid, out_side, out_kind, out_id, out_hops, still_candidate,
                  election_done, leader_id, messages_sent, last,
                  input ready);
  modport sink   (input valid, out_side, out_kind, out_id, out_hops, still_candidate,
                  election_done, leader_id, messages_sent, last,
                  output ready);
endinterface

/* hw/rtl/rle_cfg_if.sv */
// ----------------------------------------------------------------------------
// rle_cfg_if
// Register write channel of the node.
// ----------------------------------------------------------------------------
interface rle_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rle_pkg::CfgIdxW-1:0]  reg_index;
  logic [rle_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* hw/rtl/ring_leader_election_node.sv */
// ----------------------------------------------------------------------------
// ring_leader_election_node
// One node of a bidirectional ring running leader election.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        handshake
//  in_i     in   operation from_side msg_kind msg_id msg_hops    valid/ready
//  out_o    out  out_side out_kind out_id out_hops status fields valid/ready
//  cfg_i    in   reg_index wdata                                 valid/ready
//
//  one request per cycle while in_i.ready is high; state is updated in the cycle it is taken
//  each request yields one or two results into a four-entry result queue
//  in_i.ready is high while the queue has room for two results
//  with an empty queue a result shows on out_o the cycle after its request
//  results leave the queue one per cycle while out_o.ready is high
//  reset clears state and the queue; cfg_i is always ready
// ----------------------------------------------------------------------------
module ring_leader_election_node (
  input  logic      clk_i,
  input  logic      rst_ni,
  rle_in_if.sink    in_i,
  rle_out_if.source out_o,
  rle_cfg_if.sink   cfg_i
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = PtrW + 1;

  logic [rle_pkg::IdW-1:0]    own_id_q;
  logic [rle_pkg::RingW-1:0]  ring_size_q;
  logic [rle_pkg::RingW-1:0]  ring_wr;

  logic                       begun_q, begun_d;
  logic [rle_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [rle_pkg::HopW-1:0]   hop_lim_q, hop_lim_d;
  logic                       cand_q, cand_d;
  logic [rle_pkg::ReplyW-1:0] replies_q, replies_d;
  logic                       fin_q, fin_d;
  logic [rle_pkg::IdW-1:0]    leader_q, leader_d;
  logic [rle_pkg::TallyW-1:0] sent_q, sent_d;
  logic [rle_pkg::TallyW-1:0] sent_p1, sent_p2;

  logic                       in_acc, out_acc, two;
  logic                       snd0;
  rle_pkg::kind_e             k0, k1;
  logic                       side0, side1;
  logic [rle_pkg::IdW-1:0]    id0, id1;
  logic [rle_pkg::HopW-1:0]   hops0, hops1;
  logic [rle_pkg::HopW-1:0]   hops_dec;
  rle_pkg::result_t           r0, r1;

  rle_pkg::result_t           fifo_q [Depth];
  logic [PtrW-1:0]            wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]            cnt_q;
  logic [CntW-1:0]            push_n;

  assign in_acc  = in_i.valid & in_i.ready;
  assign out_acc = out_o.valid & out_o.ready;
  assign in_i.ready  = (cnt_q <= CntW'(Depth - 2));
  assign cfg_i.ready = 1'b1;

  // configuration
  always_comb begin
    ring_wr = cfg_i.wdata[rle_pkg::RingW-1:0];
    if (ring_wr < rle_pkg::MinRing) begin
      ring_wr = rle_pkg::MinRing;
    end else if (ring_wr > rle_pkg::MaxRing) begin
      ring_wr = rle_pkg::MaxRing;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q    <= '0;
      ring_size_q <= rle_pkg::MinRing;
    end else if (cfg_i.valid) begin
      unique case (rle_pkg::reg_e'(cfg_i.reg_index))
        rle_pkg::REG_OWN_ID:    own_id_q    <= cfg_i.wdata[rle_pkg::IdW-1:0];
        rle_pkg::REG_RING_SIZE: ring_size_q <= ring_wr;
        default: ;
      endcase
    end
  end

  // saturating send counts
  assign sent_p1  = (sent_q == '1) ? sent_q : sent_q + rle_pkg::TallyW'(1);
  assign sent_p2  = (sent_p1 == '1) ? sent_p1 : sent_p1 + rle_pkg::TallyW'(1);
  assign hops_dec = in_i.msg_hops - rle_pkg::HopW'(1);

  // request handling
  always_comb begin
    begun_d   = begun_q;
    phase_d   = phase_q;
    hop_lim_d = hop_lim_q;
    cand_d    = cand_q;
    replies_d = replies_q;
    fin_d     = fin_q;
    leader_d  = leader_q;
    snd0      = 1'b0;
    two       = 1'b0;
    k0        = rle_pkg::KIND_STATUS;
    side0     = rle_pkg::SideLeft;
    id0       = '0;
    hops0     = '0;
    k1        = rle_pkg::KIND_PROBE;
    side1     = rle_pkg::SideRight;
    id1       = own_id_q;
    hops1     = '0;

    unique case (rle_pkg::op_e'(in_i.operation))
      rle_pkg::OP_BEGIN: begin
        if (!fin_q) begin
          if (!begun_q) begin
            phase_d = '0;
          end else if (phase_q < rle_pkg::MaxPhase) begin
            phase_d = phase_q + rle_pkg::PhaseW'(1);
          end
          begun_d   = 1'b1;
          hop_lim_d = rle_pkg::HopW'(1) << phase_d;
          replies_d = '0;
          if (cand_q) begin
            snd0  = 1'b1;
            two   = 1'b1;
            k0    = rle_pkg::KIND_PROBE;
            side0 = rle_pkg::SideLeft;
            id0   = own_id_q;
            hops0 = hop_lim_d;
            hops1 = hop_lim_d;
          end
        end
      end
      rle_pkg::OP_MESSAGE: begin
        if (in_i.msg_hops != '0) begin
          if (rle_pkg::msg_kind_e'(in_i.msg_kind) == rle_pkg::MSG_PROBE) begin
            if (in_i.msg_id >= own_id_q) begin
              snd0 = 1'b1;
              id0  = in_i.msg_id;
              if (in_i.msg_hops == rle_pkg::HopW'(1)) begin
                k0    = rle_pkg::KIND_REPLY;
                side0 = in_i.from_side;
                hops0 = hop_lim_q;
              end else begin
                k0    = rle_pkg::KIND_PROBE;
                side0 = ~in_i.from_side;
                hops0 = hops_dec;
              end
            end
          end else if (in_i.msg_hops == rle_pkg::HopW'(1) && in_i.msg_id == own_id_q) begin
            if (replies_q != rle_pkg::ReplyMax) begin
              replies_d = replies_q + rle_pkg::ReplyW'(1);
            end
          end else begin
            snd0  = 1'b1;
            k0    = rle_pkg::KIND_REPLY;
            side0 = ~in_i.from_side;
            id0   = in_i.msg_id;
            hops0 = hops_dec;
          end
        end
      end
      rle_pkg::OP_CLOSE: begin
        if (begun_q && !fin_q) begin
          cand_d = cand_q && (replies_q == rle_pkg::ReplyOk);
          if (hop_lim_q > ring_size_q[rle_pkg::RingW-1:1] || hop_lim_q >= rle_pkg::HopCap) begin
            fin_d = 1'b1;
            if (cand_d) begin
              leader_d = own_id_q;
              snd0     = 1'b1;
              k0       = rle_pkg::KIND_ANNOUNCE;
              side0    = rle_pkg::SideRight;
              id0      = own_id_q;
            end
          end
        end
      end
      rle_pkg::OP_ANNOUNCE: begin
        if (fin_q) begin
          leader_d = in_i.msg_id;
          if (!cand_q) begin
            snd0  = 1'b1;
            k0    = rle_pkg::KIND_ANNOUNCE;
            side0 = rle_pkg::SideRight;
            id0   = in_i.msg_id;
          end
        end
      end
      default: ;
    endcase

    sent_d = two ? sent_p2 : (snd0 ? sent_p1 : sent_q);

    r0.out_side        = side0;
    r0.out_kind        = k0;
    r0.out_id          = id0;
    r0.out_hops        = hops0;
    r0.still_candidate = cand_d;
    r0.election_done   = fin_d;
    r0.leader_id       = leader_d;
    r0.messages_sent   = snd0 ? sent_p1 : sent_q;
    r0.last            = ~two;

    r1.out_side        = side1;
    r1.out_kind        = k1;
    r1.out_id          = id1;
    r1.out_hops        = hops1;
    r1.still_candidate = cand_d;
    r1.election_done   = fin_d;
    r1.leader_id       = leader_d;
    r1.messages_sent   = sent_p2;
    r1.last            = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begun_q   <= 1'b0;
      phase_q   <= '0;
      hop_lim_q <= '0;
      cand_q    <= 1'b1;
      replies_q <= '0;
      fin_q     <= 1'b0;
      leader_q  <= '0;
      sent_q    <= '0;
    end else if (in_acc) begin
      begun_q   <= begun_d;
      phase_q   <= phase_d;
      hop_lim_q <= hop_lim_d;
      cand_q    <= cand_d;
      replies_q <= replies_d;
      fin_q     <= fin_d;
      leader_q  <= leader_d;
      sent_q    <= sent_d;
    end
  end

  // result queue
  assign push_n = in_acc ? (two ? CntW'(2) : CntW'(1)) : '0;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fifo_q[wr_ptr_q] <= r0;
      if (two) begin
        fifo_q[wr_ptr_q + PtrW'(1)] <= r1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n[PtrW-1:0];
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + push_n - (out_acc ? CntW'(1) : CntW'(0));
    end
  end

  assign out_o.valid           = (cnt_q != '0);
  assign out_o.out_side        = fifo_q[rd_ptr_q].out_side;
  assign out_o.out_kind        = fifo_q[rd_ptr_q].out_kind;
  assign out_o.out_id          = fifo_q[rd_ptr_q].out_id;
  assign out_o.out_hops        = fifo_q[rd_ptr_q].out_hops;
  assign out_o.still_candidate = fifo_q[rd_ptr_q].still_candidate;
  assign out_o.election_done   = fifo_q[rd_ptr_q].election_done;
  assign out_o.leader_id       = fifo_q[rd_ptr_q].leader_id;
  assign out_o.messages_sent   = fifo_q[rd_ptr_q].messages_sent;
  assign out_o.last            = fifo_q[rd_ptr_q].last;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overflow");

  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_o.valid)
    else $error("accepted request left no result");

  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> fin_q)
    else $error("election done flag cleared");

  a_cand_no_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cand_q |=> !cand_q)
    else $error("candidate flag set again");

endmodule

/* tb/rle_election_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_election_checker
// Watches the request, result and register channels of the election node,
// keeps its own model of the node's phase, candidacy and send count, and
// compares every result field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module rle_election_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rle_in_if           req_mon,
  rle_out_if          res_mon,
  rle_cfg_if          cfg_mon,
  output int unsigned outstanding_o,
  output int unsigned checked_o,
  output int unsigned errors_o
);
  import rle_pkg::*;

  logic [IdW-1:0]    node_id;
  logic [RingW-1:0]  node_count;
  logic              ph_started;
  logic [PhaseW-1:0] ph_num;
  logic [HopW-1:0]   hop_budget;
  logic              is_candidate;
  logic [ReplyW-1:0] home_replies;
  logic              is_done;
  logic [IdW-1:0]    leader_seen;
  logic [TallyW-1:0] sent_count;

  result_t staged[$];
  result_t pending_msgs[$];

  function automatic void stage_message(logic side, kind_e kind, logic [IdW-1:0] id,
                                        logic [HopW-1:0] hops);
    result_t r;
    if (kind != KIND_STATUS && sent_count != '1) begin
      sent_count++;
    end
    r = '0;
    r.out_kind = kind;
    if (kind != KIND_STATUS) begin
      r.out_side = side;
      r.out_id   = id;
      r.out_hops = hops;
    end
    r.messages_sent = sent_count;
    staged.push_back(r);
  endfunction

  task automatic predict_election_step(op_e op, logic side, logic kind, logic [IdW-1:0] id,
                                       logic [HopW-1:0] hops);
    result_t     r;
    int unsigned span;
    staged.delete();
    case (op)
      OP_BEGIN: begin
        if (!is_done) begin
          if (!ph_started) begin
            ph_num = '0;
          end else if ((1 << ph_num) < int'(HopCap)) begin
            ph_num++;
          end
          ph_started   = 1'b1;
          hop_budget   = HopW'(1 << ph_num);
          home_replies = '0;
          if (is_candidate) begin
            stage_message(SideLeft, KIND_PROBE, node_id, hop_budget);
            stage_message(SideRight, KIND_PROBE, node_id, hop_budget);
          end
        end
      end
      OP_MESSAGE: begin
        if (hops != '0) begin
          if (kind == MSG_PROBE) begin
            if (id >= node_id) begin
              if (hops == HopW'(1)) begin
                stage_message(side, KIND_REPLY, id, hop_budget);
              end else begin
                stage_message(~side, KIND_PROBE, id, hops - 1'b1);
              end
            end
          end else if (hops == HopW'(1) && id == node_id) begin
            if (home_replies != ReplyMax) begin
              home_replies++;
            end
          end else begin
            stage_message(~side, KIND_REPLY, id, hops - 1'b1);
          end
        end
      end
      OP_CLOSE: begin
        if (ph_started && !is_done) begin
          span = 1 << ph_num;
          if (home_replies != ReplyOk) begin
            is_candidate = 1'b0;
          end
          if (span > int'(node_count) / 2 || span >= int'(HopCap)) begin
            is_done = 1'b1;
            if (is_candidate) begin
              leader_seen = node_id;
              stage_message(SideRight, KIND_ANNOUNCE, node_id, '0);
            end
          end
        end
      end
      default: begin
        if (is_done) begin
          leader_seen = id;
          if (!is_candidate) begin
            stage_message(SideRight, KIND_ANNOUNCE, id, '0);
          end
        end
      end
    endcase
    if (staged.size() == 0) begin
      stage_message(SideLeft, KIND_STATUS, '0, '0);
    end
    foreach (staged[k]) begin
      r                 = staged[k];
      r.still_candidate = is_candidate;
      r.election_done   = is_done;
      r.leader_id       = leader_seen;
      r.last            = (k == staged.size() - 1);
      pending_msgs.push_back(r);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors_o++;
    end
  endfunction

  task automatic check_result();
    result_t want;
    if (pending_msgs.size() == 0) begin
      $error("result with no request outstanding: kind %0d id %0h",
             res_mon.out_kind, res_mon.out_id);
      errors_o++;
    end else begin
      want = pending_msgs.pop_front();
      check_field("out_side", want.out_side, res_mon.out_side);
      check_field("out_kind", want.out_kind, res_mon.out_kind);
      check_field("out_id", want.out_id, res_mon.out_id);
      check_field("out_hops", want.out_hops, res_mon.out_hops);
      check_field("still_candidate", want.still_candidate, res_mon.still_candidate);
      check_field("election_done", want.election_done, res_mon.election_done);
      check_field("leader_id", want.leader_id, res_mon.leader_id);
      check_field("messages_sent", want.messages_sent, res_mon.messages_sent);
      check_field("last", want.last, res_mon.last);
    end
    checked_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id       = '0;
      node_count    = MinRing;
      ph_started    = 1'b0;
      ph_num        = '0;
      hop_budget    = '0;
      is_candidate  = 1'b1;
      home_replies  = '0;
      is_done       = 1'b0;
      leader_seen   = '0;
      sent_count    = '0;
      checked_o     = 0;
      errors_o      = 0;
      pending_msgs.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.reg_index == REG_OWN_ID) begin
          node_id = cfg_mon.wdata[IdW-1:0];
        end else begin
          node_count = cfg_mon.wdata[RingW-1:0];
          if (node_count < MinRing) begin
            node_count = MinRing;
          end else if (node_count > MaxRing) begin
            node_count = MaxRing;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_election_step(op_e'(req_mon.operation), req_mon.from_side, req_mon.msg_kind,
                              req_mon.msg_id, req_mon.msg_hops);
      end
      if (res_mon.valid && res_mon.ready) begin
        check_result();
      end
      outstanding_o <= pending_msgs.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives one ring election node through a full election: ring traffic before
// any phase, a run of phases with probes, replies and home replies, phase
// closes that keep or drop candidacy, then announcements once it is decided.
// Both channels idle at random; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import rle_pkg::*;

  localparam int unsigned CLK_HALF_NS    = 10;
  localparam int unsigned RESET_CYCLES   = 3;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned ROUNDS         = 11;
  localparam int unsigned LIMIT_CYCLES   = 100_000;

  logic clk_i = 1'b0;
  logic rst_ni;

  rle_in_if  in_ch ();
  rle_out_if out_ch ();
  rle_cfg_if cfg_ch ();

  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned mismatches;

  int unsigned requests_sent;
  int unsigned reg_writes;
  int unsigned rounds_run;
  logic        feed_quiet;
  logic        sink_quiet;
  int unsigned sink_wait;
  int unsigned sink_draw;
  logic [IdW-1:0] node_id;

  ring_leader_election_node u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  rle_election_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (in_ch),
    .res_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .outstanding_o (outstanding),
    .checked_o     (results_checked),
    .errors_o      (mismatches)
  );

  always begin
    #(CLK_HALF_NS) clk_i = 1'b1;
    #(CLK_HALF_NS) clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      sink_wait    <= 0;
      sink_quiet   <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      sink_draw = sink_quiet ? 0 : $urandom_range(0, 4);
      sink_wait    <= sink_draw;
      out_ch.ready <= (sink_draw == 0);
      if ($urandom_range(0, 39) == 0) begin
        sink_quiet <= ~sink_quiet;
      end
    end else if (sink_wait != 0) begin
      sink_wait    <= sink_wait - 1;
      out_ch.ready <= (sink_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_request(op_e op, logic side, msg_kind_e kind, logic [IdW-1:0] id,
                              logic [HopW-1:0] hops);
    int unsigned gap;
    gap = feed_quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.from_side <= side;
    in_ch.msg_kind  <= kind;
    in_ch.msg_id    <= id;
    in_ch.msg_hops  <= hops;
    do @(posedge clk_i); while (!in_ch.ready);
    requests_sent++;
  endtask

  task automatic settle_node();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_node(logic [CfgDataW-1:0] id_word, logic [CfgDataW-1:0] ring_word);
    settle_node();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= REG_OWN_ID;
    cfg_ch.wdata     <= id_word;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.reg_index <= REG_RING_SIZE;
    cfg_ch.wdata     <= ring_word;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    node_id = id_word[IdW-1:0];
    reg_writes += 2;
  endtask

  task automatic send_ring_noise();
    msg_kind_e       kind;
    logic [IdW-1:0]  id;
    logic [HopW-1:0] hops;
    if ($urandom_range(0, 9) == 0) begin
      send_request(OP_ANNOUNCE, 1'($urandom_range(0, 1)), msg_kind_e'($urandom_range(0, 1)),
                   IdW'($urandom), HopW'($urandom_range(0, 512)));
      return;
    end
    kind = msg_kind_e'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       id = node_id;
      1:       id = node_id + IdW'($urandom_range(1, 3));
      2:       id = node_id - IdW'($urandom_range(1, 3));
      default: id = IdW'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       hops = HopW'(1);
      1:       hops = HopW'($urandom_range(0, 4));
      2:       hops = HopCap;
      default: hops = HopW'($urandom_range(0, 512));
    endcase
    if (kind == MSG_REPLY && id == node_id && hops == HopW'(1)) begin
      hops = HopW'(2);
    end
    send_request(OP_MESSAGE, 1'($urandom_range(0, 1)), kind, id, hops);
  endtask

  task automatic send_any_request();
    op_e op;
    case ($urandom_range(0, 9))
      0:       op = OP_BEGIN;
      1:       op = OP_CLOSE;
      2, 3, 4: op = OP_ANNOUNCE;
      default: op = OP_MESSAGE;
    endcase
    send_request(op, 1'($urandom_range(0, 1)), msg_kind_e'($urandom_range(0, 1)),
                 IdW'($urandom), HopW'($urandom_range(0, 512)));
  endtask

  initial begin
    int unsigned lose_round;
    int unsigned home_target;
    int unsigned slots;
    int unsigned homes_left;
    logic [CfgDataW-1:0] ring_word;

    requests_sent = 0;
    reg_writes    = 0;
    rounds_run    = 0;
    feed_quiet    = 1'b0;
    node_id       = '0;
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_BEGIN;
    in_ch.from_side  <= SideLeft;
    in_ch.msg_kind   <= MSG_PROBE;
    in_ch.msg_id     <= '0;
    in_ch.msg_hops   <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_OWN_ID;
    cfg_ch.wdata     <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // traffic before any phase has begun
    program_node(16'hFFFF, 16'h0000);
    send_request(OP_CLOSE, SideLeft, MSG_PROBE, '0, '0);
    send_request(OP_ANNOUNCE, SideRight, MSG_PROBE, 16'h1234, '0);
    send_request(OP_MESSAGE, SideLeft, MSG_PROBE, 16'hFFFF, HopW'(1));
    send_request(OP_MESSAGE, SideRight, MSG_PROBE, 16'hFFFF, HopCap);
    send_request(OP_MESSAGE, SideLeft, MSG_PROBE, 16'hFFFE, HopW'(7));
    send_request(OP_MESSAGE, SideRight, MSG_PROBE, 16'hFFFF, '0);
    send_request(OP_MESSAGE, SideRight, MSG_REPLY, 16'h0000, HopCap);
    send_request(OP_MESSAGE, SideLeft, MSG_REPLY, 16'hFFFF, HopW'(1));
    send_request(OP_MESSAGE, SideLeft, MSG_REPLY, 16'h5555, HopW'(1));
    send_request(OP_MESSAGE, SideLeft, MSG_REPLY, 16'hFFFF, '0);
    program_node(16'h0000, 16'h0001);
    send_request(OP_MESSAGE, SideRight, MSG_PROBE, 16'h0000, HopW'(1));
    send_request(OP_MESSAGE, SideLeft, MSG_PROBE, 16'hAAAA, 10'h155);
    send_request(OP_MESSAGE, SideRight, MSG_REPLY, 16'h5555, 10'h2AA);

    // begin twice, then the election proper
    program_node(CfgDataW'($urandom), 16'hFFFF);
    send_request(OP_BEGIN, SideLeft, MSG_PROBE, '0, '0);
    send_request(OP_BEGIN, SideRight, MSG_REPLY, 16'hFFFF, HopCap);

    lose_round = $urandom_range(0, 13);
    for (int r = 0; r < ROUNDS; r++) begin
      feed_quiet = ($urandom_range(0, 3) == 0);
      send_request(OP_BEGIN, 1'($urandom_range(0, 1)), msg_kind_e'($urandom_range(0, 1)),
                   IdW'($urandom), HopW'($urandom_range(0, 512)));
      if (r == lose_round) begin
        case ($urandom_range(0, 3))
          0:       home_target = 0;
          1:       home_target = 1;
          2:       home_target = 3;
          default: home_target = 4;
        endcase
      end else begin
        home_target = 2;
      end
      homes_left = home_target;
      slots      = $urandom_range(30, 42) + home_target;
      for (int s = 0; s < slots; s++) begin
        if (homes_left != 0 && $urandom_range(0, slots - 1 - s) < homes_left) begin
          send_request(OP_MESSAGE, 1'($urandom_range(0, 1)), MSG_REPLY, node_id, HopW'(1));
          homes_left--;
        end else begin
          send_ring_noise();
        end
      end
      send_request(OP_CLOSE, 1'($urandom_range(0, 1)), msg_kind_e'($urandom_range(0, 1)),
                   IdW'($urandom), HopW'($urandom_range(0, 512)));
      rounds_run++;
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0:       ring_word = 16'd1024;
          1:       ring_word = 16'd2047;
          2:       ring_word = 16'hFFFF;
          3:       ring_word = 16'd1500;
          default: ring_word = CfgDataW'($urandom_range(2, 1023));
        endcase
        program_node(CfgDataW'($urandom), ring_word);
      end
    end

    // decided node: announcements, stray phases and ring traffic
    feed_quiet = 1'b0;
    program_node(16'h0000, 16'h0002);
    repeat (45) send_any_request();
    program_node(CfgDataW'($urandom), 16'd1024);
    feed_quiet = 1'b1;
    repeat (15) send_any_request();
    feed_quiet = 1'b0;
    repeat (30) send_any_request();

    settle_node();
    $display("ran %0d requests over %0d election rounds with %0d register writes",
             requests_sent, rounds_run, reg_writes);
    $display("compared %0d node results, %0d field mismatches", results_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ring_leader_election_node regression: pass");
    end else begin
      $display("ring_leader_election_node regression: fail");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF_NS);
    $display("timed out waiting for the node");
    $display("ring_leader_election_node regression: fail");
    $finish;
  end

endmodule
